// ----- hdl/vrt_pkg.sv -----
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants of the region table
// Field widths, result status codes, request kinds, the sequencer state
// encoding and the stored region record.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int ADDR_W   = 39;
  localparam int END_W    = 40;
  localparam int FLAG_W   = 4;
  localparam int WORD_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

  // Request kinds.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_INSERT = 3'b010,
    S_SCAN   = 3'b100
  } state_e;

  // One stored region.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [END_W-1:0]  stop;
    logic [FLAG_W-1:0] flags;
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] bytes;
  } region_t;

endpackage

// ----- hdl/vrt_region_mem.sv -----
// ----------------------------------------------------------------------------
// vrt_region_mem: region storage
// Single write port and a single read port with registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module vrt_region_mem #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  vrt_pkg::region_t wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output vrt_pkg::region_t rdata_o
);

  vrt_pkg::region_t mem_q [ENTRIES];
  vrt_pkg::region_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/vrt_range_match.sv -----
// ----------------------------------------------------------------------------
// vrt_range_match: shared range comparator
// Tells whether an address falls in the half-open range [start, stop) of
// one region. The scan reuses it for every slot in turn.
// ----------------------------------------------------------------------------
module vrt_range_match (
  input  logic [vrt_pkg::ADDR_W-1:0] address_i,
  input  vrt_pkg::region_t           region_i,
  output logic                       hit_o
);

  logic [vrt_pkg::END_W-1:0] addr_ext;

  // An empty region has start equal to stop and can never hit.
  assign addr_ext = {1'b0, address_i};
  assign hit_o    = (address_i >= region_i.start) && (addr_ext < region_i.stop);

endmodule

// ----- hdl/vma_region_table_unit.sv -----
// ----------------------------------------------------------------------------
// vma_region_table_unit: virtual memory region table
// Appends regions and finds the first region that holds an address.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. An insert
// stores the region in the next free slot and reports that slot, echoing the
// region with its end set to start plus length; with every slot used it
// reports table full and all other fields zero. A lookup walks the filled
// slots in slot order through one shared range comparator, one slot per
// cycle behind the registered memory read, and reports the lowest slot
// whose [start, end) holds the address, or a miss with all other fields
// zero. An insert writes the region and loads the result register from the
// insert state, a full table or an empty-table lookup loads it straight
// from idle, and a lookup loads it from the scan state at the first hit or
// after the last filled slot. The walk over the memory read port sets the
// lookup time. The result beat is shown on the output ports for exactly one
// cycle with done_o high; there is no way to stall it, so the receiver must
// take it in that cycle. busy stays high while an insert or a scan is in
// progress, and a new request may be issued in the very cycle that a result
// is shown. Region storage needs no clearing after reset, since only slots
// below the fill count are ever used.
// ----------------------------------------------------------------------------
module vma_region_table_unit #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind_i,
  input  logic [vrt_pkg::ADDR_W-1:0]    address_i,
  input  logic [vrt_pkg::ADDR_W-1:0]    span_length_i,
  input  logic [vrt_pkg::FLAG_W-1:0]    region_flags_i,
  input  logic [vrt_pkg::WORD_W-1:0]    file_offset_i,
  input  logic [vrt_pkg::WORD_W-1:0]    file_bytes_i,
  output logic                          done_o,
  output logic [vrt_pkg::STATUS_W-1:0]  status_o,
  output logic [vrt_pkg::SLOT_W-1:0]    slot_o,
  output logic [vrt_pkg::ADDR_W-1:0]    region_start_o,
  output logic [vrt_pkg::END_W-1:0]     region_end_o,
  output logic [vrt_pkg::FLAG_W-1:0]    out_flags_o,
  output logic [vrt_pkg::WORD_W-1:0]    out_file_offset_o,
  output logic [vrt_pkg::WORD_W-1:0]    out_file_bytes_o
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Sequencer and fill state.
  vrt_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic             tag_vld_q, tag_vld_d;
  logic [CNT_W-1:0] tag_idx_q, tag_idx_d;
  logic [CNT_W-1:0] tag_next;

  // Captured request beat.
  logic [vrt_pkg::ADDR_W-1:0] req_addr_q;
  logic [vrt_pkg::ADDR_W-1:0] req_len_q;
  logic [vrt_pkg::FLAG_W-1:0] req_flags_q;
  logic [vrt_pkg::WORD_W-1:0] req_off_q;
  logic [vrt_pkg::WORD_W-1:0] req_bytes_q;

  // Result register.
  logic                         done_q, done_d;
  logic                         res_load;
  logic [vrt_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [vrt_pkg::SLOT_W-1:0]   res_slot_q, res_slot_d;
  vrt_pkg::region_t             res_region_q, res_region_d;

  // Datapath.
  logic             accept;
  logic             hit;
  vrt_pkg::region_t new_region;
  vrt_pkg::region_t rd_region;
  logic             mem_we;
  logic [IDX_W+3:0] ins_ext;
  logic [IDX_W+3:0] tag_ext;

  assign busy   = (state_q != vrt_pkg::S_IDLE);
  assign accept = start && !busy;

  // The new region; its end cannot wrap past 40 bits.
  assign new_region.start  = req_addr_q;
  assign new_region.stop   = {1'b0, req_addr_q} + {1'b0, req_len_q};
  assign new_region.flags  = req_flags_q;
  assign new_region.offset = req_off_q;
  assign new_region.bytes  = req_bytes_q;

  // Slot numbers are reported modulo 16.
  assign ins_ext  = {4'b0000, count_q[IDX_W-1:0]};
  assign tag_ext  = {4'b0000, tag_idx_q[IDX_W-1:0]};
  assign tag_next = tag_idx_q + CNT_W'(1);

  vrt_region_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (new_region),
    .raddr_i (scan_q[IDX_W-1:0]),
    .rdata_o (rd_region)
  );

  vrt_range_match u_match (
    .address_i (req_addr_q),
    .region_i  (rd_region),
    .hit_o     (hit)
  );

  // The scan issues one read per cycle; tag_idx_q names the slot whose data
  // sits in the read register, and tag_vld_q says whether that slot is filled.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_d       = scan_q;
    tag_vld_d    = 1'b0;
    tag_idx_d    = tag_idx_q;
    done_d       = 1'b0;
    res_load     = 1'b0;
    res_status_d = vrt_pkg::STATUS_OK;
    res_slot_d   = '0;
    res_region_d = '0;
    mem_we       = 1'b0;

    case (state_q)
      vrt_pkg::S_IDLE: begin
        if (accept) begin
          if (kind_i == vrt_pkg::KIND_INSERT) begin
            if (count_q == CNT_W'(ENTRIES)) begin
              res_load     = 1'b1;
              res_status_d = vrt_pkg::STATUS_FULL;
              done_d       = 1'b1;
            end else begin
              state_d = vrt_pkg::S_INSERT;
            end
          end else if (count_q == '0) begin
            res_load     = 1'b1;
            res_status_d = vrt_pkg::STATUS_MISS;
            done_d       = 1'b1;
          end else begin
            scan_d  = '0;
            state_d = vrt_pkg::S_SCAN;
          end
        end
      end

      vrt_pkg::S_INSERT: begin
        mem_we       = 1'b1;
        count_d      = count_q + CNT_W'(1);
        res_load     = 1'b1;
        res_status_d = vrt_pkg::STATUS_OK;
        res_slot_d   = ins_ext[3:0];
        res_region_d = new_region;
        done_d       = 1'b1;
        state_d      = vrt_pkg::S_IDLE;
      end

      vrt_pkg::S_SCAN: begin
        scan_d    = scan_q + CNT_W'(1);
        tag_vld_d = (scan_q < count_q);
        tag_idx_d = scan_q;
        if (tag_vld_q) begin
          if (hit) begin
            res_load     = 1'b1;
            res_status_d = vrt_pkg::STATUS_OK;
            res_slot_d   = tag_ext[3:0];
            res_region_d = rd_region;
            done_d       = 1'b1;
            tag_vld_d    = 1'b0;
            state_d      = vrt_pkg::S_IDLE;
          end else if (tag_next == count_q) begin
            res_load     = 1'b1;
            res_status_d = vrt_pkg::STATUS_MISS;
            done_d       = 1'b1;
            tag_vld_d    = 1'b0;
            state_d      = vrt_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_d = vrt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= vrt_pkg::S_IDLE;
      count_q   <= '0;
      scan_q    <= '0;
      tag_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      scan_q    <= scan_d;
      tag_vld_q <= tag_vld_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_idx_q <= tag_idx_d;
    if (accept) begin
      req_addr_q  <= address_i;
      req_len_q   <= span_length_i;
      req_flags_q <= region_flags_i;
      req_off_q   <= file_offset_i;
      req_bytes_q <= file_bytes_i;
    end
    if (res_load) begin
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_region_q <= res_region_d;
    end
  end

  assign done_o            = done_q;
  assign status_o          = res_status_q;
  assign slot_o            = res_slot_q;
  assign region_start_o    = res_region_q.start;
  assign region_end_o      = res_region_q.stop;
  assign out_flags_o       = res_region_q.flags;
  assign out_file_offset_o = res_region_q.offset;
  assign out_file_bytes_o  = res_region_q.bytes;

endmodule

// ----- hdl/vrt_checker.sv -----
// ----------------------------------------------------------------------------
// vrt_checker: port-level checks of the region table
// Watches the request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module vrt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic [vrt_pkg::STATUS_W-1:0] status_o,
  input logic [vrt_pkg::SLOT_W-1:0]   slot_o,
  input logic [vrt_pkg::ADDR_W-1:0]   region_start_o,
  input logic [vrt_pkg::END_W-1:0]    region_end_o,
  input logic [vrt_pkg::FLAG_W-1:0]   out_flags_o,
  input logic [vrt_pkg::WORD_W-1:0]   out_file_offset_o,
  input logic [vrt_pkg::WORD_W-1:0]   out_file_bytes_o
);

  // An accepted request either keeps the unit busy or answers at once.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted request neither started work nor answered");

  // A result only follows a request beat or a busy period.
  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start)))
    else $error("result beat without a request");

  // Table full and miss results carry no region.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == vrt_pkg::STATUS_FULL || status_o == vrt_pkg::STATUS_MISS))
    |-> (slot_o == '0 && region_start_o == '0 && region_end_o == '0 &&
         out_flags_o == '0 && out_file_offset_o == '0 && out_file_bytes_o == '0))
    else $error("full or miss result with nonzero fields");

  // A reported region never ends before it starts.
  a_region_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == vrt_pkg::STATUS_OK) |-> (region_end_o >= {1'b0, region_start_o}))
    else $error("region end below region start");

endmodule

bind vma_region_table_unit vrt_checker u_vrt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .done_o            (done_o),
  .status_o          (status_o),
  .slot_o            (slot_o),
  .region_start_o    (region_start_o),
  .region_end_o      (region_end_o),
  .out_flags_o       (out_flags_o),
  .out_file_offset_o (out_file_offset_o),
  .out_file_bytes_o  (out_file_bytes_o)
);
